>>> src/fbfl_pkg.sv
// Shared types and constants for the fixed block free-list allocator.
// Used by the allocator top and the divider; depends on nothing.
package fbfl_pkg;

   // Fixed field widths of the request, response and register words.
   localparam int OFF_W     = 20;
   localparam int BS_W      = 13;
   localparam int NB_W      = 9;
   localparam int FCOUNT_W  = 9;
   localparam int CSR_W     = 13;

   // Built-in defaults for the top-level parameters.
   localparam int DEF_MAX_BLOCKS  = 256;
   localparam int DEF_OFFSET_BITS = 20;

   // Register reset values.
   localparam logic [BS_W-1:0] BLOCK_SIZE_RST = BS_W'(64);
   localparam logic [NB_W-1:0] NUM_BLOCKS_RST = NB_W'(256);

   typedef enum logic [0:0] {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_REJECTED  = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_BLOCK_SIZE = 1'b0,
      CSR_NUM_BLOCKS = 1'b1
   } csr_index_type;

   typedef struct packed {
      req_kind_type      req_type;
      logic [OFF_W-1:0]  free_offset;
   } req_word_type;

   typedef struct packed {
      status_type           status;
      logic [OFF_W-1:0]     block_offset;
      logic [FCOUNT_W-1:0]  free_count;
   } rsp_word_type;

   // Outcome of the offset divider, handed to the control logic.
   typedef struct packed {
      logic              done;
      logic [OFF_W-1:0]  quotient;
      logic [BS_W-1:0]   remainder;
   } div_result_type;

endpackage

>>> src/fixed_block_free_list_allocator.sv
// Fixed-size block pool allocator with a last-in-first-out free list.
//
// Requests arrive on the req_ channel (valid/ready). Each word either
// allocates a block or frees the block at free_offset. Exactly one response
// word per request leaves on the rsp_ channel (valid/ready), in order, with
// a status, the byte offset of an allocated block and the free count.
// The user must set the block size and the number of blocks through the csr_
// write port only while idle; the block itself does not enforce this.
//
// An accepted allocate passes through S_ALLOC, which pops the list with the
// link already read at the head, or else takes the watermark block, and
// forms the offset with a single multiply; S_OUT then loads the response
// register. A free waits in S_DIV for the restoring divider, which produces
// one quotient bit per cycle over the 20-bit offset. One request is in flight
// at a time, so a new word is taken only once the last response is loaded.
// The response register parts the two sides: a finished word waits there
// while the receiver stalls, the next request is worked on meanwhile and
// then holds req_ready low until the register frees up.
// Reset empties the list and the watermark and restores a 64-byte block
// size with 256 blocks; the link table needs no clearing pass.
module fixed_block_free_list_allocator
   import fbfl_pkg::*;
#(
   parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_word_type  req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_word_type  rsp_data,
   input  logic          csr_wr_en,
   input  csr_index_type csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_A_W = $clog2(MAX_BLOCKS + 1);
   localparam int CNT_W   = (CNT_A_W > NB_W) ? CNT_A_W : NB_W;
   localparam int PROD_W  = IDX_W + BS_W;
   localparam int WIDE_W  = (PROD_W > OFF_W) ? PROD_W : OFF_W;
   localparam int MASK_W  = (OFFSET_BITS < OFF_W) ? OFFSET_BITS : OFF_W;
   localparam logic [OFF_W-1:0] OFF_MASK = OFF_W'((64'(1) << MASK_W) - 64'(1));

   typedef enum logic [1:0] {
      S_IDLE,
      S_ALLOC,
      S_DIV,
      S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [BS_W-1:0]     block_size_ff, block_size_in;
   logic [NB_W-1:0]     num_blocks_ff, num_blocks_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic                list_empty_ff, list_empty_in;
   logic [CNT_W-1:0]    fresh_ff, fresh_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   status_type          status_ff, status_in;
   logic [OFF_W-1:0]    offset_ff, offset_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_data_ff, rsp_data_in;

   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [IDX_W-1:0]    ram_wr_data;
   logic [IDX_W-1:0]    ram_rd_data;

   logic                div_start;
   div_result_type      div_res;

   logic [CNT_W-1:0]    pool;
   logic [CNT_W-1:0]    nb_ext;
   logic [CNT_W-1:0]    fresh_left;
   logic [CNT_W:0]      total;
   logic [CNT_W-1:0]    free_cnt;

   logic [IDX_W-1:0]    alloc_idx;
   logic                alloc_got;
   logic [CNT_W-1:0]    len_dec;
   logic [WIDE_W-1:0]   product;
   logic                free_ok;
   logic [IDX_W-1:0]    free_idx;

   // Link table: next_link of each listed block.
   fbfl_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // Offset divider for the range and alignment check of a free.
   fbfl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_data.free_offset),
      .divisor  (block_size_ff),
      .result   (div_res)
   );

   // Pool size in blocks and the number of free blocks.
   always_comb begin
      nb_ext = CNT_W'(num_blocks_ff);
      if (block_size_ff == '0) begin
         pool = '0;
      end else if (nb_ext > CNT_W'(MAX_BLOCKS)) begin
         pool = CNT_W'(MAX_BLOCKS);
      end else begin
         pool = nb_ext;
      end
      fresh_left = (fresh_ff < pool) ? (pool - fresh_ff) : '0;
      total      = {1'b0, len_ff} + {1'b0, fresh_left};
      free_cnt   = (total > {1'b0, pool}) ? pool : total[CNT_W-1:0];
   end

   // Allocate: pop the list top, else hand out the watermark block.
   always_comb begin
      alloc_got = 1'b0;
      alloc_idx = head_ff;
      len_dec   = (len_ff != '0) ? (len_ff - CNT_W'(1)) : len_ff;
      if (!list_empty_ff) begin
         alloc_got = 1'b1;
      end else if (fresh_ff < pool) begin
         alloc_got = 1'b1;
         alloc_idx = fresh_ff[IDX_W-1:0];
      end
      product = WIDE_W'(alloc_idx) * WIDE_W'(block_size_ff);
   end

   // Free: the quotient must name a block of the pool with no remainder.
   always_comb begin
      free_ok  = (pool != '0) && (div_res.quotient < OFF_W'(pool))
                 && (div_res.remainder == '0);
      free_idx = div_res.quotient[IDX_W-1:0];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign div_start = req_valid && (state_ff == S_IDLE)
                      && (req_data.req_type == REQ_FREE);

   // Control sequence, list update and response register loading.
   always_comb begin
      state_in      = state_ff;
      block_size_in = block_size_ff;
      num_blocks_in = num_blocks_ff;
      head_in       = head_ff;
      list_empty_in = list_empty_ff;
      fresh_in      = fresh_ff;
      len_in        = len_ff;
      status_in     = status_ff;
      offset_in     = offset_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = free_idx;
      ram_wr_data   = list_empty_ff ? '0 : head_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE: block_size_in = csr_wdata[BS_W-1:0];
            CSR_NUM_BLOCKS: num_blocks_in = csr_wdata[NB_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.req_type == REQ_FREE) ? S_DIV : S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (!list_empty_ff) begin
               len_in = len_dec;
               if (len_dec == '0) begin
                  list_empty_in = 1'b1;
               end else begin
                  head_in = ram_rd_data;
               end
            end else if (alloc_got) begin
               fresh_in = fresh_ff + CNT_W'(1);
            end
            status_in = alloc_got ? ST_DONE : ST_EXHAUSTED;
            offset_in = alloc_got ? (product[OFF_W-1:0] & OFF_MASK) : '0;
            state_in  = S_OUT;
         end
         S_DIV: begin
            if (div_res.done) begin
               if (free_ok) begin
                  ram_wr_en     = 1'b1;
                  head_in       = free_idx;
                  list_empty_in = 1'b0;
                  if (len_ff < CNT_W'(MAX_BLOCKS)) begin
                     len_in = len_ff + CNT_W'(1);
                  end
               end
               status_in = free_ok ? ST_DONE : ST_REJECTED;
               offset_in = '0;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.block_offset  = offset_ff;
               rsp_data_in.free_count    = FCOUNT_W'(free_cnt);
               state_in                  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         block_size_ff <= BLOCK_SIZE_RST;
         num_blocks_ff <= NUM_BLOCKS_RST;
         head_ff       <= '0;
         list_empty_ff <= 1'b1;
         fresh_ff      <= '0;
         len_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         block_size_ff <= block_size_in;
         num_blocks_ff <= num_blocks_in;
         head_ff       <= head_in;
         list_empty_ff <= list_empty_in;
         fresh_ff      <= fresh_in;
         len_ff        <= len_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      status_ff   <= status_in;
      offset_ff   <= offset_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The list is empty exactly when its length is zero.
   assert property (@(posedge clock) disable iff (reset)
      list_empty_ff == (len_ff == '0))
      else $error("list empty flag disagrees with list length");

   // The watermark never passes the built maximum.
   assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= CNT_W'(MAX_BLOCKS))
      else $error("watermark beyond the built maximum");

   // A divider result only arrives while a free is waiting for it.
   assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == S_DIV))
      else $error("divider result outside of a free");

   // A new response word is only loaded from the output state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("response raised outside of the output state");

   // The link table is written only when a free completes.
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (div_res.done && free_ok))
      else $error("link table written without an accepted free");

endmodule

>>> src/fbfl_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; holds the link table of the free list.
module fbfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/fbfl_div.sv
// Restoring divider, one quotient bit per cycle, for the alignment check of a free.
// Depends on fbfl_pkg for the offset and block size widths.
module fbfl_div
   import fbfl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OFF_W-1:0]  dividend,
   input  logic [BS_W-1:0]   divisor,
   output div_result_type    result
);

   localparam int STEPS = OFF_W;
   localparam int STEP_W = $clog2(STEPS);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [OFF_W-1:0]   quo_ff, quo_in;
   logic [BS_W-1:0]    rem_ff, rem_in;

   logic [BS_W:0]      shifted;
   logic [BS_W:0]      divisor_ext;
   logic [BS_W:0]      diff;
   logic               fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      shifted     = {rem_ff, quo_ff[OFF_W-1]};
      divisor_ext = {1'b0, divisor};
      fits        = (shifted >= divisor_ext);
      diff        = shifted - divisor_ext;
   end

   // Next-state logic for the iteration counter and the partial results.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[OFF_W-2:0], fits};
         rem_in  = fits ? diff[BS_W-1:0] : shifted[BS_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

   // A result comes only at the end of a run that was started.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider reports done while still busy");

endmodule
